[src/polyev_pkg.sv]
// shared types and constants for the polynomial evaluator
// no dependencies; imported by polyev_step and polynomial_evaluator
package polyev_pkg;

  localparam int DATA_W        = 32;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int CFG_IDX_W     = 3;
  localparam int TERM_W        = 3;
  localparam int MAX_TERMS_DEF = 7;
  localparam int FRAC_BITS_DEF = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BASE  = 3'd1;

  // one item as it moves between Horner steps
  typedef struct packed {
    logic                     valid;
    logic                     ovf;
    logic signed [DATA_W-1:0] acc;
    logic signed [DATA_W-1:0] x;
  } beat_t;

endpackage

[src/polyev_step.sv]
// one Horner step in two register stages: multiply, then round, add and saturate
// depends on polyev_pkg
module polyev_step #(
  parameter int FRAC_BITS = polyev_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  polyev_pkg::beat_t                   i_beat,
  input  logic signed [polyev_pkg::DATA_W-1:0] i_coef,
  output polyev_pkg::beat_t                   o_beat
);
  import polyev_pkg::*;

  localparam logic signed [PROD_W-1:0] HALF =
    (FRAC_BITS == 0) ? '0 : (PROD_W'(1) <<< (FRAC_BITS - 1));
  localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(64'sd2147483647);
  localparam logic signed [PROD_W-1:0] SAT_MIN = -PROD_W'(64'sd2147483648);

  // multiply stage
  logic                     m_valid_r, m_valid_nxt;
  logic                     m_ovf_r;
  logic signed [DATA_W-1:0] m_x_r;
  logic signed [PROD_W-1:0] m_prod_r;
  logic signed [PROD_W-1:0] prod;

  // round / add / saturate stage
  beat_t                    o_beat_r, o_beat_nxt;
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-1:0] sum;
  logic signed [PROD_W-1:0] coef_ext;

  always_comb begin
    prod        = PROD_W'(i_beat.acc) * PROD_W'(i_beat.x);
    m_valid_nxt = i_beat.valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (en) begin
      m_valid_r <= m_valid_nxt;
    end
    if (en) begin
      m_ovf_r  <= i_beat.ovf;
      m_x_r    <= i_beat.x;
      m_prod_r <= prod;
    end
  end

  always_comb begin
    coef_ext         = {{(PROD_W-DATA_W){i_coef[DATA_W-1]}}, i_coef};
    // arithmetic shift gives floor, so adding half rounds ties upward
    rnd              = (m_prod_r + HALF) >>> FRAC_BITS;
    sum              = rnd + coef_ext;
    o_beat_nxt.valid = m_valid_r;
    o_beat_nxt.x     = m_x_r;
    o_beat_nxt.ovf   = m_ovf_r;
    if (sum > SAT_MAX) begin
      o_beat_nxt.acc = SAT_MAX[DATA_W-1:0];
      o_beat_nxt.ovf = 1'b1;
    end else if (sum < SAT_MIN) begin
      o_beat_nxt.acc = SAT_MIN[DATA_W-1:0];
      o_beat_nxt.ovf = 1'b1;
    end else begin
      o_beat_nxt.acc = sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_beat_r.valid <= 1'b0;
    end else if (en) begin
      o_beat_r.valid <= o_beat_nxt.valid;
    end
    if (en) begin
      o_beat_r.ovf <= o_beat_nxt.ovf;
      o_beat_r.acc <= o_beat_nxt.acc;
      o_beat_r.x   <= o_beat_nxt.x;
    end
  end

  assign o_beat = o_beat_r;

`ifndef ASSERT_OFF
  a_valid_moves: assert property (@(posedge clk) disable iff (!rst_n)
    en && m_valid_r |=> o_beat_r.valid)
    else $error("valid beat dropped between multiply and add stages");
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    en && m_valid_r && m_ovf_r |=> o_beat_r.ovf)
    else $error("overflow flag cleared by a later step");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en && o_beat_r.valid |=> $stable(o_beat_r))
    else $error("stage changed while stalled");
`endif

endmodule

[src/polynomial_evaluator.sv]
// Horner polynomial evaluator, signed Q16.16, top level
// depends on polyev_pkg and polyev_step
//
// usage:
//   in_valid / in_ready carry one x_value beat per cycle while in_ready is high.
//   out_valid / out_ready return y_value and overflow, one beat per input,
//   in input order.
//   cfg_valid / cfg_ready write term_count (index 0) or coef_0..coef_6
//   (indexes 1..7); write only while no beats are in flight. cfg_ready is
//   always high. Writes to coefficients beyond MAX_TERMS are dropped.
// structure: each Horner step is one multiply stage and one
//   round/add/saturate stage, and every item runs all MAX_TERMS steps, with
//   coefficients at or above the term count taken as zero.
// throughput: one beat per cycle while the output is not stalled, limited by
//   the single 32x32 multiplier per step.
// reset: synchronous, clears all pipeline valid bits, term_count and
//   coefficients to zero.
// stall: when out_valid is high and out_ready low the whole pipeline holds
//   and in_ready drops; nothing is lost or repeated.
module polynomial_evaluator #(
  parameter int MAX_TERMS = polyev_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = polyev_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [polyev_pkg::DATA_W-1:0]    in_x_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [polyev_pkg::DATA_W-1:0]    out_y_value,
  output logic                                   out_overflow,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [polyev_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [polyev_pkg::DATA_W-1:0]           cfg_data
);
  import polyev_pkg::*;

  logic [TERM_W-1:0]        term_count_r;
  logic signed [DATA_W-1:0] coef_r [MAX_TERMS];
  logic                     cfg_we;
  logic                     en;
  beat_t                    beat [MAX_TERMS+1];

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_count_r <= '0;
    end else if (cfg_we && cfg_index == REG_TERM_COUNT) begin
      term_count_r <= cfg_data[TERM_W-1:0];
    end
  end

  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_coef
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        coef_r[i] <= '0;
      end else if (cfg_we && cfg_index == CFG_IDX_W'(int'(REG_COEF_BASE) + i)) begin
        coef_r[i] <= cfg_data;
      end
    end
  end

  // whole pipeline advances unless the output beat is held
  assign en       = !beat[MAX_TERMS].valid || out_ready;
  assign in_ready = en;

  always_comb begin
    beat[0].valid = in_valid;
    beat[0].ovf   = 1'b0;
    beat[0].acc   = '0;
    beat[0].x     = in_x_value;
  end

  for (genvar j = 0; j < MAX_TERMS; j++) begin : g_step
    localparam int K = MAX_TERMS - 1 - j;
    logic signed [DATA_W-1:0] coef_eff;

    // terms at or above the count read as zero, so the accumulator stays zero
    assign coef_eff = (term_count_r > TERM_W'(K)) ? coef_r[K] : '0;

    polyev_step #(
      .FRAC_BITS(FRAC_BITS)
    ) u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .i_beat (beat[j]),
      .i_coef (coef_eff),
      .o_beat (beat[j+1])
    );
  end

  assign out_valid    = beat[MAX_TERMS].valid;
  assign out_y_value  = beat[MAX_TERMS].acc;
  assign out_overflow = beat[MAX_TERMS].ovf;

`ifndef ASSERT_OFF
  a_ready_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output is stalled");
  a_zero_terms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && term_count_r == '0 |-> out_y_value == '0 && !out_overflow)
    else $error("nonzero result with zero term count");
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_y_value))
    else $error("output beat changed while stalled");
`endif

endmodule
